// ===== src/aligned_column_variant_caller_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the aligned column variant caller
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_COLUMN_VARIANT_CALLER_MACROS_SVH
`define ALIGNED_COLUMN_VARIANT_CALLER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ACVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ACVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/acvc_pkg.sv =====
// ----------------------------------------------------------------------------
// acvc_pkg
// Shared types and constants of the aligned column variant caller.
// ----------------------------------------------------------------------------
`default_nettype none

package acvc_pkg;

  // Gap symbol in the alignment
  localparam logic [7:0] GAP_BASE = 8'd45;

  // Row counter stops here
  localparam logic [10:0] ROW_LIMIT = 11'd2047;

  // Register reset values
  localparam logic [15:0] START_POS_RST  = 16'd16534;
  localparam logic [15:0] GENOME_LEN_RST = 16'd16569;
  localparam logic [15:0] GROUP_NUM_RST  = 16'd1;

  // Register word indexes on the config port
  localparam logic [1:0] REG_START_POS  = 2'd0;
  localparam logic [1:0] REG_GENOME_LEN = 2'd1;
  localparam logic [1:0] REG_GROUP_NUM  = 2'd2;

  typedef enum logic [1:0] {
    KIND_SUB = 2'd0,
    KIND_DEL = 2'd1,
    KIND_INS = 2'd2
  } acvc_kind_e;

  typedef struct packed {
    logic [15:0] start_pos;
    logic [15:0] genome_len;
    logic [15:0] group_num;
  } acvc_cfg_t;

  typedef struct packed {
    logic [15:0] ref_position;
    logic [15:0] sub_position;
    acvc_kind_e  change_kind;
    logic [7:0]  from_base;
    logic [7:0]  to_base;
    logic [9:0]  match_count;
    logic [9:0]  group_size;
    logic [15:0] record_group;
  } acvc_rec_t;

endpackage

`default_nettype wire

// ===== src/acvc_core.sv =====
// ----------------------------------------------------------------------------
// acvc_core
// Column scan state and per-row compare logic; decides whether an item emits.
// ----------------------------------------------------------------------------
`default_nettype none

module acvc_core #(
  parameter int unsigned MAX_MEMBERS = 1023
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire acvc_pkg::acvc_cfg_t cfg_i,
  input  wire logic              accept_i,
  input  wire logic [7:0]        base_i,
  input  wire logic              column_end_i,
  input  wire logic              new_scan_i,
  output logic                   emit_o,
  output acvc_pkg::acvc_rec_t    rec_o
);
  import acvc_pkg::*;

  localparam int unsigned CountCap = (MAX_MEMBERS < 1023) ? MAX_MEMBERS : 1023;
  localparam logic [9:0]  CapVal   = 10'(CountCap);
  localparam logic [10:0] CapWide  = 11'(CountCap);

  logic [15:0] pos_q, pos_d, pos_eff;
  logic [15:0] sub_q, sub_d, sub_eff;
  logic [10:0] row_q, row_d, row_eff;
  logic [7:0]  ref_q, ref_d;
  logic [7:0]  ovr_q, ovr_d;
  logic [7:0]  grp_q, grp_d;
  logic [9:0]  match_q, match_d;
  logic [16:0] pos_inc;
  logic [10:0] members_w;
  logic [9:0]  members;
  logic        full_col;
  acvc_kind_e  kind;

  // Scan start overrides the running position
  always_comb begin
    pos_eff = new_scan_i ? cfg_i.start_pos : pos_q;
    sub_eff = new_scan_i ? 16'd0 : sub_q;
    row_eff = new_scan_i ? 11'd0 : row_q;
  end

  // Capture the three header rows and count matching members
  always_comb begin
    ref_d   = ref_q;
    ovr_d   = ovr_q;
    grp_d   = grp_q;
    match_d = match_q;
    priority if (row_eff == 11'd0) begin
      ref_d = base_i;
    end else if (row_eff == 11'd1) begin
      ovr_d = base_i;
    end else if (row_eff == 11'd2) begin
      grp_d   = base_i;
      match_d = 10'd0;
    end else if (base_i == grp_q && match_q < CapVal) begin
      match_d = match_q + 10'd1;
    end
  end

  // Advance the row on each item; move position and subposition at the column end
  always_comb begin
    pos_inc  = {1'b0, pos_eff} + 17'd1;
    full_col = column_end_i && (row_eff >= 11'd2);
    pos_d    = pos_eff;
    sub_d    = sub_eff;
    if (!column_end_i) begin
      row_d = (row_eff < ROW_LIMIT) ? row_eff + 11'd1 : ROW_LIMIT;
    end else begin
      row_d = 11'd0;
    end
    if (full_col) begin
      if (ref_d != GAP_BASE) begin
        pos_d = (pos_inc > {1'b0, cfg_i.genome_len}) ? 16'd1 : pos_inc[15:0];
        sub_d = 16'd0;
      end else if (ovr_d != GAP_BASE || grp_d != GAP_BASE) begin
        sub_d = (sub_eff != 16'hFFFF) ? sub_eff + 16'd1 : sub_eff;
      end
    end
  end

  // Build the record
  always_comb begin
    members_w = row_eff - 11'd2;
    members   = (members_w > CapWide) ? CapVal : members_w[9:0];
    priority if (ovr_d == GAP_BASE) begin
      kind = KIND_INS;
    end else if (grp_d == GAP_BASE) begin
      kind = KIND_DEL;
    end else begin
      kind = KIND_SUB;
    end
    emit_o = full_col && (ovr_d != grp_d) && (pos_d != cfg_i.start_pos);
    rec_o.ref_position = pos_d;
    rec_o.sub_position = sub_d;
    rec_o.change_kind  = kind;
    rec_o.from_base    = ovr_d;
    rec_o.to_base      = grp_d;
    rec_o.match_count  = match_d;
    rec_o.group_size   = members;
    rec_o.record_group = cfg_i.group_num;
  end

  // Commit state on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= START_POS_RST;
      sub_q   <= 16'd0;
      row_q   <= 11'd0;
      ref_q   <= 8'd0;
      ovr_q   <= 8'd0;
      grp_q   <= 8'd0;
      match_q <= 10'd0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      sub_q   <= sub_d;
      row_q   <= row_d;
      ref_q   <= ref_d;
      ovr_q   <= ovr_d;
      grp_q   <= grp_d;
      match_q <= match_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/acvc_outbuf.sv =====
// ----------------------------------------------------------------------------
// acvc_outbuf
// Output register with one skid entry; the input side stalls only when
// the skid entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module acvc_outbuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire acvc_pkg::acvc_rec_t rec_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output acvc_pkg::acvc_rec_t      rec_o
);
  import acvc_pkg::*;

  logic      main_vld_q, main_vld_d;
  logic      skid_vld_q, skid_vld_d;
  acvc_rec_t main_q, main_d;
  acvc_rec_t skid_q, skid_d;
  logic      pop;

  assign pop         = main_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign rec_o       = main_q;

  // Move items between skid, main register and output
  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_d     = rec_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = rec_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      main_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ===== src/aligned_column_variant_caller.sv =====
// ----------------------------------------------------------------------------
// aligned_column_variant_caller
// Takes one base of an aligned column per item (reference row, overall
// consensus, group consensus, then members) and issues at most one
// difference record per column. An item is taken every clock cycle unless
// the input stalls; its record is registered in a two-entry output buffer,
// and the input stalls only when both buffer entries are full.
// Registers on the APB port: 0x0 start position, 0x4 genome length,
// 0x8 group number.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_column_variant_caller #(
  parameter int unsigned MAX_MEMBERS = 1023
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  base_i,
  input  wire logic        column_end_i,
  input  wire logic        new_scan_i,
  // Result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      ref_position_o,
  output logic [15:0]      sub_position_o,
  output logic [1:0]       change_kind_o,
  output logic [7:0]       from_base_o,
  output logic [7:0]       to_base_o,
  output logic [9:0]       match_count_o,
  output logic [9:0]       group_size_o,
  output logic [15:0]      record_group_o
);
  import acvc_pkg::*;

  acvc_cfg_t cfg_q;
  acvc_rec_t core_rec, out_rec;
  logic      cfg_wr;
  logic      accept;
  logic      emit;
  logic      buf_full;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_pos  <= START_POS_RST;
      cfg_q.genome_len <= GENOME_LEN_RST;
      cfg_q.group_num  <= GROUP_NUM_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START_POS:  cfg_q.start_pos  <= pwdata[15:0];
        REG_GENOME_LEN: cfg_q.genome_len <= pwdata[15:0];
        REG_GROUP_NUM:  cfg_q.group_num  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_POS:  prdata = {16'd0, cfg_q.start_pos};
      REG_GENOME_LEN: prdata = {16'd0, cfg_q.genome_len};
      REG_GROUP_NUM:  prdata = {16'd0, cfg_q.group_num};
      default:        prdata = 32'd0;
    endcase
  end

  // Handshake
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  acvc_core #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .base_i       (base_i),
    .column_end_i (column_end_i),
    .new_scan_i   (new_scan_i),
    .emit_o       (emit),
    .rec_o        (core_rec)
  );

  acvc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .rec_i       (core_rec),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (out_rec)
  );

  // Drive result fields
  assign ref_position_o = out_rec.ref_position;
  assign sub_position_o = out_rec.sub_position;
  assign change_kind_o  = out_rec.change_kind;
  assign from_base_o    = out_rec.from_base;
  assign to_base_o      = out_rec.to_base;
  assign match_count_o  = out_rec.match_count;
  assign group_size_o   = out_rec.group_size;
  assign record_group_o = out_rec.record_group;

endmodule

`default_nettype wire

// ===== src/acvc_checker.sv =====
// ----------------------------------------------------------------------------
// acvc_checker
// Port-level checks of the aligned column variant caller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aligned_column_variant_caller_macros.svh"

module acvc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  base_i,
  input wire logic        column_end_i,
  input wire logic        new_scan_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] ref_position_o,
  input wire logic [15:0] sub_position_o,
  input wire logic [1:0]  change_kind_o,
  input wire logic [7:0]  from_base_o,
  input wire logic [7:0]  to_base_o,
  input wire logic [9:0]  match_count_o,
  input wire logic [9:0]  group_size_o,
  input wire logic [15:0] record_group_o
);
  import acvc_pkg::*;

  // Stalled record holds
  `ACVC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(ref_position_o) && $stable(from_base_o) && $stable(match_count_o), "stalled record changed")

  // A record always reports a real difference
  `ACVC_ASSERT_NOW(a_bases_differ, out_valid_o, from_base_o != to_base_o, "record with equal bases")

  // Matches never exceed the group size
  `ACVC_ASSERT_NOW(a_match_le_size, out_valid_o, match_count_o <= group_size_o, "match count above group size")

  // Insertion exactly when the overall base is a gap
  `ACVC_ASSERT_NOW(a_ins_kind, out_valid_o, (change_kind_o == KIND_INS) == (from_base_o == GAP_BASE), "insertion kind mismatch")

  // Deletion needs a gap group base over a real overall base
  `ACVC_ASSERT_NOW(a_del_kind, out_valid_o && change_kind_o == KIND_DEL, to_base_o == GAP_BASE && from_base_o != GAP_BASE, "deletion kind mismatch")

endmodule

bind aligned_column_variant_caller acvc_checker u_acvc_checker (.*);

`default_nettype wire

// ===== sim/tb_aligned_column_variant_caller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aligned_column_variant_caller
// Feeds aligned columns row by row into the variant caller, predicts the
// difference records in the bench and checks every record field by field.
// Covers a directed table, one long column and random columns under
// several register settings, including position wrap and zero genome length.
// ----------------------------------------------------------------------------

module tb_aligned_column_variant_caller;
  import acvc_pkg::*;

  localparam int unsigned MAX_MEMBERS = 1023;
  localparam int unsigned MEMBER_CAP  = (MAX_MEMBERS < 1023) ? MAX_MEMBERS : 1023;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned LONG_ROWS   = 64;

  localparam logic [7:0] BASE_A = 8'h41;
  localparam logic [7:0] BASE_C = 8'h43;
  localparam logic [7:0] BASE_G = 8'h47;
  localparam logic [7:0] BASE_T = 8'h54;
  localparam acvc_rec_t  NO_REC = '0;

  typedef struct {
    logic [7:0] base;
    logic       col_end;
    logic       scan;
    bit         typed;
    bit         has_rec;
    acvc_rec_t  rec;
  } dir_row_t;

  // DUT ports
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  base_i       = '0;
  logic        column_end_i = 1'b0;
  logic        new_scan_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [15:0] ref_position_o;
  logic [15:0] sub_position_o;
  logic [1:0]  change_kind_o;
  logic [7:0]  from_base_o;
  logic [7:0]  to_base_o;
  logic [9:0]  match_count_o;
  logic [9:0]  group_size_o;
  logic [15:0] record_group_o;

  // Typed expectation that travels with the item on the input side
  bit          row_typed   = 1'b0;
  bit          row_has_rec = 1'b0;
  acvc_rec_t   row_rec     = '0;

  // Register copy and column state of the bench
  logic [15:0] cfg_start   = START_POS_RST;
  logic [15:0] cfg_glen    = GENOME_LEN_RST;
  logic [15:0] cfg_gnum    = GROUP_NUM_RST;
  logic [15:0] col_pos     = START_POS_RST;
  logic [15:0] col_subpos  = '0;
  logic [10:0] col_row     = '0;
  logic [7:0]  ref_held    = '0;
  logic [7:0]  overall_held = '0;
  logic [7:0]  group_held  = '0;
  logic [9:0]  member_hits = '0;

  acvc_rec_t   variant_q[$];
  dir_row_t    dir_rows[$];
  bit          idle_on     = 1'b1;
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned recs_checked = 0;
  int unsigned settings_run = 1;

  logic [15:0] ph_start [5] = '{16'd0, 16'd65535, 16'd5, 16'd3, 16'd0};
  logic [15:0] ph_glen  [5] = '{16'd1, 16'd65535, 16'd7, 16'd0, 16'd0};
  logic [15:0] ph_gnum  [5] = '{16'd65535, 16'd1, 16'h1234, 16'hA5A5, 16'd0};

  aligned_column_variant_caller #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .base_i        (base_i),
    .column_end_i  (column_end_i),
    .new_scan_i    (new_scan_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ref_position_o(ref_position_o),
    .sub_position_o(sub_position_o),
    .change_kind_o (change_kind_o),
    .from_base_o   (from_base_o),
    .to_base_o     (to_base_o),
    .match_count_o (match_count_o),
    .group_size_o  (group_size_o),
    .record_group_o(record_group_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up after a fixed time
  initial begin
    #10_000_000;
    $display("tb_aligned_column_variant_caller failed");
    $finish;
  end

  function automatic acvc_rec_t mk_rec(input logic [15:0] pos, input logic [15:0] sub,
                                       input acvc_kind_e kind, input logic [7:0] from_b,
                                       input logic [7:0] to_b, input logic [9:0] m,
                                       input logic [9:0] n, input logic [15:0] grp);
    acvc_rec_t r;
    r.ref_position = pos;
    r.sub_position = sub;
    r.change_kind  = kind;
    r.from_base    = from_b;
    r.to_base      = to_b;
    r.match_count  = m;
    r.group_size   = n;
    r.record_group = grp;
    return r;
  endfunction

  // Append one row to the directed table
  task automatic add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Advance the column state by one row; report the record it yields, if any
  task automatic call_row(input logic [7:0] b, input logic col_end, input logic scan,
                          output bit got, output acvc_rec_t r);
    logic [10:0] row;
    int          next_pos;
    int unsigned members;
    got = 1'b0;
    r   = NO_REC;
    if (scan) begin
      col_pos    = cfg_start;
      col_subpos = '0;
      col_row    = '0;
    end
    row = col_row;
    if (row == 11'd0) begin
      ref_held = b;
    end else if (row == 11'd1) begin
      overall_held = b;
    end else if (row == 11'd2) begin
      group_held  = b;
      member_hits = '0;
    end else if (b == group_held && member_hits < MEMBER_CAP) begin
      member_hits = member_hits + 10'd1;
    end
    if (!col_end) begin
      col_row = (row < ROW_LIMIT) ? row + 11'd1 : ROW_LIMIT;
      return;
    end
    col_row = '0;
    // Short column: nothing moves
    if (row < 11'd2) return;
    if (ref_held != GAP_BASE) begin
      next_pos   = int'(col_pos) + 1;
      col_pos    = (next_pos > int'(cfg_glen)) ? 16'd1 : next_pos[15:0];
      col_subpos = '0;
    end else if (overall_held != GAP_BASE || group_held != GAP_BASE) begin
      if (col_subpos != 16'hFFFF) col_subpos = col_subpos + 16'd1;
    end
    if (overall_held != group_held && col_pos != cfg_start) begin
      members = row - 2;
      if (members > MEMBER_CAP) members = MEMBER_CAP;
      got = 1'b1;
      r = mk_rec(col_pos, col_subpos,
                 (overall_held == GAP_BASE) ? KIND_INS :
                 (group_held == GAP_BASE) ? KIND_DEL : KIND_SUB,
                 overall_held, group_held, member_hits, members[9:0], cfg_gnum);
    end
  endtask

  // Predict on every accepted item
  always @(posedge clk_i) begin : take_item
    bit        got;
    acvc_rec_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      call_row(base_i, column_end_i, new_scan_i, got, r);
      if (row_typed) begin
        if (row_has_rec) variant_q.insert(variant_q.size(), row_rec);
      end else if (got) begin
        variant_q.insert(variant_q.size(), r);
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each accepted record with the oldest prediction
  always @(posedge clk_i) begin : check_record
    acvc_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (variant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual pos %0d kind %0d",
                 $time, ref_position_o, change_kind_o);
      end else begin
        want = variant_q.pop_front();
        recs_checked++;
        check_field("ref_position", want.ref_position, ref_position_o);
        check_field("sub_position", want.sub_position, sub_position_o);
        check_field("change_kind", want.change_kind, change_kind_o);
        check_field("from_base", want.from_base, from_base_o);
        check_field("to_base", want.to_base, to_base_o);
        check_field("match_count", want.match_count, match_count_o);
        check_field("group_size", want.group_size, group_size_o);
        check_field("record_group", want.record_group, record_group_o);
      end
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic col_end, input logic scan,
                           input bit typed, input bit has_rec, input acvc_rec_t rec);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_i       <= b;
    column_end_i <= col_end;
    new_scan_i   <= scan;
    row_typed    <= typed;
    row_has_rec  <= has_rec;
    row_rec      <= rec;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(7))
      0:       return BASE_A;
      1:       return BASE_C;
      2:       return BASE_G;
      3:       return BASE_T;
      4, 5:    return GAP_BASE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random column; some are short, some carry a stray scan restart
  task automatic send_column(input bit scan);
    int         rows;
    logic [7:0] overall;
    logic [7:0] grp;
    logic [7:0] b;
    rows    = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
    overall = pick_base();
    grp     = $urandom_range(1) ? overall : pick_base();
    for (int i = 0; i < rows; i++) begin
      if (i == 0)      b = pick_base();
      else if (i == 1) b = overall;
      else if (i == 2) b = grp;
      else             b = ($urandom_range(2) == 0) ? pick_base() : grp;
      send_item(b, i == rows - 1, (i == 0 && scan) || $urandom_range(49) == 0,
                1'b0, 1'b0, NO_REC);
    end
  endtask

  // Wait until every record is in and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (variant_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_START_POS:  cfg_start = val;
      REG_GENOME_LEN: cfg_glen  = val;
      REG_GROUP_NUM:  cfg_gnum  = val;
      default: ;
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[15:0] != val) begin
      errors++;
      $display("%0t: register %0d readback, expected %0d, actual %0d",
               $time, idx, val, prdata[15:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned phase_base;

    // Directed columns under reset settings
    add_row('{BASE_A,   1'b0, 1'b1, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_C,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_G,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_G,   1'b1, 1'b0, 1'b1, 1'b1,
              mk_rec(16'd16535, 16'd0, KIND_SUB, BASE_C, BASE_G,
                     10'd1, 10'd1, GROUP_NUM_RST)});
    // Insertion column
    add_row('{GAP_BASE, 1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{GAP_BASE, 1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_T,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_T,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{GAP_BASE, 1'b1, 1'b0, 1'b1, 1'b1,
              mk_rec(16'd16535, 16'd1, KIND_INS, GAP_BASE, BASE_T,
                     10'd1, 10'd2, GROUP_NUM_RST)});
    // Deletion column: gapped members count as matches
    add_row('{BASE_A,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_A,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{GAP_BASE, 1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{GAP_BASE, 1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{GAP_BASE, 1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_A,   1'b1, 1'b0, 1'b1, 1'b1,
              mk_rec(16'd16536, 16'd0, KIND_DEL, BASE_A, GAP_BASE,
                     10'd2, 10'd3, GROUP_NUM_RST)});
    // Short column: silent
    add_row('{8'hFF,    1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{8'h00,    1'b1, 1'b0, 1'b1, 1'b0, NO_REC});
    // Three rows, no members, extreme codes
    add_row('{8'h00,    1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{8'hFF,    1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{8'h00,    1'b1, 1'b0, 1'b1, 1'b1,
              mk_rec(16'd16537, 16'd0, KIND_SUB, 8'hFF, 8'h00,
                     10'd0, 10'd0, GROUP_NUM_RST)});
    // Equal consensus bases
    add_row('{BASE_A,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_G,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_G,   1'b1, 1'b0, 1'b0, 1'b0, NO_REC});
    // Restart: the column stays at the start position and is not reported
    add_row('{GAP_BASE, 1'b0, 1'b1, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_C,   1'b0, 1'b0, 1'b0, 1'b0, NO_REC});
    add_row('{BASE_G,   1'b1, 1'b0, 1'b1, 1'b0, NO_REC});

    // Reset
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].base, dir_rows[i].col_end, dir_rows[i].scan,
                dir_rows[i].typed, dir_rows[i].has_rec, dir_rows[i].rec);
    end

    // Long column: every member matches the group base
    for (int i = 0; i < LONG_ROWS; i++) begin
      send_item((i == 0) ? BASE_A : (i == 1) ? BASE_C : BASE_G, i == LONG_ROWS - 1,
                1'b0, 1'b0, 1'b0, NO_REC);
    end
    drain();

    // Random columns under several settings
    ph_start[4] = 16'($urandom_range(65535));
    ph_glen[4]  = 16'($urandom_range(1, 65535));
    ph_gnum[4]  = 16'($urandom_range(1, 65535));
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_START_POS, ph_start[ph]);
      write_reg(REG_GENOME_LEN, ph_glen[ph]);
      write_reg(REG_GROUP_NUM, ph_gnum[ph]);
      settings_run++;
      idle_on    = (ph != 2);
      phase_base = items_sent;
      send_column(1'b1);
      while (items_sent - phase_base < PHASE_ITEMS) send_column(1'b0);
      drain();
    end
    idle_on = 1'b1;

    $display("Sent %0d items, checked %0d records under %0d register settings.",
             items_sent, recs_checked, settings_run);
    $display("Included short and long columns, position wrap, zero genome length"
             , " and a full-rate stretch.");
    if (errors == 0) begin
      $display("tb_aligned_column_variant_caller passed");
    end else begin
      $display("tb_aligned_column_variant_caller failed");
    end
    $finish;
  end

endmodule

// ===== aligned_column_variant_caller.f =====
+incdir+src
src/acvc_pkg.sv
src/acvc_core.sv
src/acvc_outbuf.sv
src/aligned_column_variant_caller.sv
src/acvc_checker.sv
sim/tb_aligned_column_variant_caller.sv
